// ===== rtl/core/pls_pkg.sv =====
`timescale 1ns / 1ps
package pls_pkg;
    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_BEST   = 3'd2;
    localparam logic [2:0] OP_EMPTY  = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DOMINATED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BADIDX    = 3'd4;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] best_first;
        logic [31:0] best_second;
        logic [4:0]  best_position;
        logic        all_empty;
    } t_result;
endpackage

// ===== rtl/core/pareto_label_set_engine_core.sv =====
`timescale 1ns / 1ps
// Pareto label set engine.
// Input channel: i_valid / o_stall with opcode, list index, position, two
// 16.16 costs and an empty-check bound. Output channel: o_valid / i_stall
// with status, best costs, best position and the all-empty flag; one
// result beat per input beat, in order.
// Configuration: i_cfg_valid / o_cfg_ready writes lists_in_use; ready is
// only given while the block is idle, no result waits and no beat is offered.
// Operation: insert, remove and query walk the chosen list through the label
// memory, one read-compare-write step per entry; a step that walks nothing
// (empty check, clear, bad index, empty list, remove of the last label)
// skips the walk. The registered read of the label memory sets the pace.
// One item is worked at a time; the next beat is accepted in the cycle after
// the result moves into the output register. That register holds a finished
// result while the receiver stalls, and the next item may be accepted and
// worked meanwhile, waiting only at hand-over.
// Reset (synchronous, active low) empties all lists and sets lists_in_use
// to 16; no clearing pass is needed since list lengths live in flip-flops.
module pareto_label_set_engine_core #(
    parameter int NUM_LISTS  = 16,
    parameter int MAX_LABELS = 32,
    parameter int COST_BITS  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_opcode,
    input  logic [3:0]  i_list_index,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_cost_first,
    input  logic [31:0] i_cost_second,
    input  logic [4:0]  i_empty_bound,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [31:0] o_best_first,
    output logic [31:0] o_best_second,
    output logic [4:0]  o_best_position,
    output logic        o_all_empty,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data
);
    import pls_pkg::*;

    localparam int LW  = $clog2(NUM_LISTS) > 0 ? $clog2(NUM_LISTS) : 1;
    localparam int PW  = $clog2(MAX_LABELS);
    localparam int CW  = PW + 1;
    localparam int AW  = LW + PW;
    localparam int DW  = 2 * COST_BITS;
    localparam int NW  = $clog2(NUM_LISTS + 1);

    // internal code: no walk and no length update
    localparam logic [2:0] OP_SKIP = 3'd5;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RUN  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]     r_state, n_state;
    logic [4:0]     r_cfg;
    logic [CW-1:0]  r_len [NUM_LISTS];
    logic [2:0]     r_op;
    logic [LW-1:0]  r_li;
    logic [PW-1:0]  r_pos;
    logic [COST_BITS-1:0] r_c1, r_c2;
    logic [CW-1:0]  r_rd, r_keep, r_cnt;
    logic           r_rvalid, r_disc;
    logic [COST_BITS-1:0] r_bmax, r_bmin;
    logic [PW-1:0]  r_best;
    logic           r_have;
    logic [DW-1:0]  r_bdata;
    t_result        r_res;
    logic           r_ovalid;

    logic [NW-1:0]  w_n;
    logic           w_we;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [DW-1:0]  w_wdata, w_rdata;
    logic [COST_BITS-1:0] w_e1, w_e2, w_mx, w_mn;
    logic           w_cdom, w_edom, w_better;
    logic           w_acc;
    logic [CW-1:0]  w_len;
    logic [2:0]     w_op_in;
    logic [LW-1:0]  w_li_in;
    logic [CW-1:0]  w_rd_in, w_keep_in, w_cnt_in;
    t_result        w_res_in;

    // effective list count, saturated into 1..NUM_LISTS
    always_comb begin
        if (r_cfg == 5'd0) begin
            w_n = NW'(1);
        end else if (32'(r_cfg) > NUM_LISTS) begin
            w_n = NW'(NUM_LISTS);
        end else begin
            w_n = NW'(r_cfg);
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE) && !r_ovalid && !i_valid;
    assign o_stall     = (r_state != S_IDLE);
    assign w_acc       = i_valid && !o_stall;
    assign w_len       = r_len[r_li];

    pls_label_mem #(.DEPTH(1 << AW), .WIDTH(DW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_e1 = w_rdata[DW-1:COST_BITS];
    assign w_e2 = w_rdata[COST_BITS-1:0];
    assign w_cdom = (r_c1 < w_e1 && r_c2 <= w_e2) || (r_c1 <= w_e1 && r_c2 < w_e2);
    assign w_edom = (w_e1 < r_c1 && w_e2 <= r_c2) || (w_e1 <= r_c1 && w_e2 < r_c2);
    assign w_mx = (w_e1 > w_e2) ? w_e1 : w_e2;
    assign w_mn = (w_e1 > w_e2) ? w_e2 : w_e1;
    assign w_better = !r_have || (w_mx < r_bmax) || (w_mx == r_bmax && w_mn < r_bmin);

    // read address walks the list; write address compacts it
    assign w_raddr = {r_li, r_rd[PW-1:0]};
    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_li, r_keep[PW-1:0]};
        w_wdata = w_rdata;
        if (r_state == S_RUN && r_rvalid) begin
            unique case (r_op)
                OP_INSERT: w_we = !w_cdom;
                OP_REMOVE: w_we = (r_cnt > CW'(r_pos));
                default:   w_we = 1'b0;
            endcase
        end else if (r_state == S_FIN && r_op == OP_INSERT && !r_disc
                     && r_keep < CW'(MAX_LABELS)) begin
            w_we    = 1'b1;
            w_wdata = {r_c1, r_c2};
        end
        if (r_op == OP_REMOVE) begin
            w_waddr = {r_li, r_keep[PW-1:0]};
        end
    end

    // decode an incoming beat: pick the list, skip the walk where none is needed
    always_comb begin
        w_op_in   = i_opcode;
        w_li_in   = LW'(i_list_index);
        w_rd_in   = '0;
        w_keep_in = '0;
        w_cnt_in  = '0;
        w_res_in  = '0;
        if (i_opcode == OP_BEST) begin
            w_li_in = LW'(w_n - 1'b1);
        end
        if (i_opcode == OP_INSERT || i_opcode == OP_REMOVE) begin
            if (32'(i_list_index) >= 32'(w_n)) begin
                w_res_in.status = ST_BADIDX;
                w_rd_in = CW'(MAX_LABELS);
                w_op_in = OP_SKIP;
            end else if (i_opcode == OP_REMOVE) begin
                if (r_len[LW'(i_list_index)] == '0) begin
                    w_res_in.status = ST_EMPTY;
                    w_rd_in = CW'(MAX_LABELS);
                end else if (CW'(i_position) >= r_len[LW'(i_list_index)]
                             || 32'(i_position) >= MAX_LABELS) begin
                    w_res_in.status = ST_BADIDX;
                    w_rd_in = CW'(MAX_LABELS);
                end else begin
                    w_keep_in = CW'(i_position);
                    w_rd_in   = CW'(i_position) + 1'b1;
                    w_cnt_in  = CW'(i_position) + 1'b1;
                end
            end
        end else if (i_opcode == OP_EMPTY) begin
            w_rd_in = CW'(MAX_LABELS);
            if (32'(i_empty_bound) > 32'(w_n)) begin
                w_res_in.status = ST_BADIDX;
            end else begin
                w_res_in.all_empty = 1'b1;
                for (int k = 0; k < NUM_LISTS; k++) begin
                    if (k < 32'(i_empty_bound) && r_len[k] != '0) begin
                        w_res_in.all_empty = 1'b0;
                    end
                end
            end
        end else if (i_opcode != OP_BEST) begin
            w_rd_in = CW'(MAX_LABELS);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_acc) n_state = S_RUN;
            S_RUN:  if (r_rd >= w_len && !r_rvalid) n_state = S_FIN;
            S_FIN:  n_state = S_DONE;
            S_DONE: if (!r_ovalid || !i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= 5'd16;
            r_ovalid <= 1'b0;
            r_rvalid <= 1'b0;
            for (int k = 0; k < NUM_LISTS; k++) r_len[k] <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_cfg <= i_cfg_data;
            if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_rvalid <= (r_state == S_RUN) && (r_rd < w_len);
            if (r_state == S_FIN) begin
                unique case (r_op)
                    OP_INSERT: r_len[r_li] <= (!r_disc && r_keep < CW'(MAX_LABELS))
                                              ? r_keep + 1'b1 : r_keep;
                    OP_REMOVE: if (r_res.status == ST_OK) r_len[r_li] <= w_len - 1'b1;
                    OP_CLEAR:  for (int k = 0; k < NUM_LISTS; k++) r_len[k] <= '0;
                    default: ;
                endcase
            end
        end
    end

    // datapath: capture item, walk the list, form the result
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op   <= w_op_in;
            r_li   <= w_li_in;
            r_pos  <= PW'(i_position);
            r_c1   <= COST_BITS'(i_cost_first);
            r_c2   <= COST_BITS'(i_cost_second);
            r_rd   <= w_rd_in;
            r_keep <= w_keep_in;
            r_cnt  <= w_cnt_in;
            r_disc <= 1'b0;
            r_have <= 1'b0;
            r_best <= '0;
            r_res  <= w_res_in;
        end else if (r_state == S_RUN) begin
            if (r_rd < w_len) r_rd <= r_rd + 1'b1;
            if (r_rvalid) begin
                r_cnt <= r_cnt + 1'b1;
                unique case (r_op)
                    OP_INSERT: begin
                        if (!w_cdom) r_keep <= r_keep + 1'b1;
                        if (!w_cdom && w_edom) r_disc <= 1'b1;
                    end
                    OP_REMOVE: r_keep <= r_keep + 1'b1;
                    OP_BEST: begin
                        if (w_better) begin
                            r_have  <= 1'b1;
                            r_bmax  <= w_mx;
                            r_bmin  <= w_mn;
                            r_best  <= r_cnt[PW-1:0];
                            r_bdata <= w_rdata;
                        end
                    end
                    default: ;
                endcase
            end
        end else if (r_state == S_FIN) begin
            unique case (r_op)
                OP_INSERT: r_res.status <= r_disc ? ST_DOMINATED
                    : (r_keep >= CW'(MAX_LABELS) ? ST_FULL : ST_OK);
                OP_BEST: begin
                    if (!r_have) begin
                        r_res.status <= ST_EMPTY;
                    end else begin
                        r_res.best_first    <= 32'(r_bdata[DW-1:COST_BITS]);
                        r_res.best_second   <= 32'(r_bdata[COST_BITS-1:0]);
                        r_res.best_position <= 5'(r_best);
                    end
                end
                default: ;
            endcase
        end
    end

    // output register: load at hand-over, hold while stalled
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || !i_stall)) begin
            o_status        <= r_res.status;
            o_best_first    <= r_res.best_first;
            o_best_second   <= r_res.best_second;
            o_best_position <= r_res.best_position;
            o_all_empty     <= r_res.all_empty;
        end
    end
    assign o_valid = r_ovalid;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall)
        else $error("item accepted while busy");
    a_no_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> !o_cfg_ready)
        else $error("config ready during work");
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_len[r_li] <= CW'(MAX_LABELS)))
        else $error("list length overflow");
endmodule

// ===== rtl/core/pls_label_mem.sv =====
`timescale 1ns / 1ps
module pls_label_mem #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write one entry, read one entry with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
